/* src/lvc_pkg.sv */
package lvc_pkg;

  // Widths of the request and result fields
  localparam int unsigned VIDX_W  = 16;
  localparam int unsigned COUNT_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [VIDX_W-1:0] vertex_index;
    logic              end_of_element;
    logic              restart;
  } in_req_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] miss_total;
    logic [COUNT_W-1:0] element_total;
  } out_res_t;

  // Control that every cell sees in the same cycle
  typedef struct packed {
    logic capture;   // compare the new index against the stored slot
    logic clear;     // empty the slot (restart with this request)
    logic commit;    // apply the move-to-front shift
  } cell_ctl_t;

endpackage

/* src/lvc_cell.sv */
module lvc_cell #(
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lvc_pkg::cell_ctl_t     ctl,
  input  logic [INDEX_WIDTH-1:0] idx,
  input  logic [INDEX_WIDTH-1:0] prev_slot,
  input  logic                   prev_valid,
  input  logic                   seen_in,
  output logic                   seen_out,
  output logic [INDEX_WIDTH-1:0] slot_out,
  output logic                   valid_out
);

  logic [INDEX_WIDTH-1:0] slot_r;
  logic                   valid_r;
  logic                   match_r;
  logic                   shift;

  // Shift from the neighbor unless the hit lies ahead of this cell
  assign shift    = ~seen_in;
  assign seen_out = seen_in | match_r;

  // Latch the compare result for the commit cycle
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match_r <= valid_r & ~ctl.clear & (slot_r == idx);
    end
  end

  // Hold valid bit; clear on restart, take neighbor's on shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.capture && ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.commit && shift) begin
      valid_r <= prev_valid;
    end
  end

  // Advance slot contents on shift
  always_ff @(posedge clk) begin
    if (ctl.commit && shift) begin
      slot_r <= prev_slot;
    end
  end

  assign slot_out  = slot_r;
  assign valid_out = valid_r;

endmodule

/* src/lvc_chain.sv */
module lvc_chain #(
  parameter int unsigned CACHE_DEPTH = 32,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lvc_pkg::cell_ctl_t     ctl,
  input  logic [INDEX_WIDTH-1:0] idx,
  input  logic [INDEX_WIDTH-1:0] front_idx,
  output logic                   hit
);

  logic [INDEX_WIDTH-1:0] slot  [CACHE_DEPTH+1];
  logic                   valid [CACHE_DEPTH+1];
  logic                   seen  [CACHE_DEPTH+1];

  // Front of the row takes the new index
  assign slot[0]  = front_idx;
  assign valid[0] = 1'b1;
  assign seen[0]  = 1'b0;

  for (genvar k = 0; k < CACHE_DEPTH; k++) begin : g_cell
    lvc_cell #(
      .INDEX_WIDTH(INDEX_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .idx       (idx),
      .prev_slot (slot[k]),
      .prev_valid(valid[k]),
      .seen_in   (seen[k]),
      .seen_out  (seen[k+1]),
      .slot_out  (slot[k+1]),
      .valid_out (valid[k+1])
    );
  end

  // Oldest entry falls off the end; a match anywhere is a hit
  assign hit = seen[CACHE_DEPTH];

endmodule

/* src/lru_vertex_cache_miss_counter.sv */
// The compare result is registered when a request is accepted; then, once the
// result register is free, the cache row shifts and the result register loads
// together, raising out_valid.
// A new request is accepted only after the previous one has finished its
// compare-then-shift pass through the row of cache cells; a waiting result
// holds the shift, so one more request is accepted and then in_ready stays low until out_ready.
// Reset: synchronous active-low rst_n empties the cache, zeroes both counts
// and drops any request in flight.
module lru_vertex_cache_miss_counter #(
  parameter int unsigned CACHE_DEPTH = 32,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lvc_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lvc_pkg::out_res_t out_data
);

  logic                         busy_r;
  logic [INDEX_WIDTH-1:0]       idx_r;
  logic                         eoe_r;
  logic [lvc_pkg::COUNT_W-1:0]  miss_r;
  logic [lvc_pkg::COUNT_W-1:0]  elem_r;
  logic                         out_valid_r;
  lvc_pkg::out_res_t            out_data_r;
  logic [INDEX_WIDTH-1:0]       idx;
  logic                         accept;
  logic                         commit;
  logic                         hit;
  logic [lvc_pkg::COUNT_W-1:0]  miss_nxt;
  logic [lvc_pkg::COUNT_W-1:0]  elem_nxt;
  lvc_pkg::cell_ctl_t           ctl;

  // Keep the low index bits, zero-extend for a wider cache tag
  if (INDEX_WIDTH <= lvc_pkg::VIDX_W) begin : g_idx_trunc
    assign idx = in_data.vertex_index[INDEX_WIDTH-1:0];
  end else begin : g_idx_ext
    assign idx = {{(INDEX_WIDTH - lvc_pkg::VIDX_W){1'b0}}, in_data.vertex_index};
  end

  assign in_ready = ~busy_r;
  assign accept   = in_valid & in_ready;
  assign commit   = busy_r & (~out_valid_r | out_ready);

  assign ctl.capture = accept;
  assign ctl.clear   = in_data.restart;
  assign ctl.commit  = commit;

  lvc_chain #(
    .CACHE_DEPTH(CACHE_DEPTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .idx      (idx),
    .front_idx(idx_r),
    .hit      (hit)
  );

  // Saturating count updates for the request in flight
  always_comb begin
    miss_nxt = miss_r;
    elem_nxt = elem_r;
    if (!hit && miss_r != lvc_pkg::COUNT_MAX) begin
      miss_nxt = miss_r + 1'b1;
    end
    if (eoe_r && elem_r != lvc_pkg::COUNT_MAX) begin
      elem_nxt = elem_r + 1'b1;
    end
  end

  // Hold the request fields for the commit cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= idx;
      eoe_r <= in_data.end_of_element;
    end
  end

  // Track the request in flight and the counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      miss_r <= '0;
      elem_r <= '0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        if (in_data.restart) begin
          miss_r <= '0;
          elem_r <= '0;
        end
      end else if (commit) begin
        busy_r <= 1'b0;
        miss_r <= miss_nxt;
        elem_r <= elem_nxt;
      end
    end
  end

  // Load the result register; drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r.hit           <= hit;
      out_data_r.miss_total    <= miss_nxt;
      out_data_r.element_total <= elem_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/lvc_checker.sv */
module lvc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input lvc_pkg::out_res_t out_data
);

  // A result waiting for the consumer holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Requests are never accepted back to back
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted on back-to-back cycles");

  // A reported miss is always counted
  a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.miss_total != '0)
    else $error("miss result with zero miss count");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind lru_vertex_cache_miss_counter lvc_checker u_lvc_checker (.*);
